// ===== design/olsd_pkg.sv =====
// shared constants, types and codes for the ordered list store
package olsd_pkg;

  // store geometry
  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef logic [SLOT_W-1:0]             slot_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  // request codes
  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_SEARCH    = 2'd2,
    OP_DELETE    = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TAIL,
    S_SCAN,
    S_LINK1,
    S_LINK2,
    S_WALK,
    S_DONE
  } state_t;

  // write ports and shared read address of the slot store
  typedef struct packed {
    logic  val_we;
    slot_t val_waddr;
    val_t  val_wdata;
    logic  nxt_we;
    slot_t nxt_waddr;
    slot_t nxt_wdata;
    logic  prv_we;
    slot_t prv_waddr;
    slot_t prv_wdata;
    slot_t raddr;
  } store_cmd_t;

  // registered read data of one slot
  typedef struct packed {
    val_t  val;
    slot_t nxt;
    slot_t prv;
  } store_rd_t;

endpackage

// ===== design/olsd_store.sv =====
// slot store: value, next link and previous link memories
module olsd_store (
  input  logic                   clk,
  input  olsd_pkg::store_cmd_t   cmd,
  output olsd_pkg::store_rd_t    rd
);

  olsd_pkg::val_t  val_mem [olsd_pkg::CAPACITY];
  olsd_pkg::slot_t nxt_mem [olsd_pkg::CAPACITY];
  olsd_pkg::slot_t prv_mem [olsd_pkg::CAPACITY];

  // value, next link and previous link memories with one shared read address
  always_ff @(posedge clk) begin
    if (cmd.val_we) begin
      val_mem[cmd.val_waddr] <= cmd.val_wdata;
    end
    if (cmd.nxt_we) begin
      nxt_mem[cmd.nxt_waddr] <= cmd.nxt_wdata;
    end
    if (cmd.prv_we) begin
      prv_mem[cmd.prv_waddr] <= cmd.prv_wdata;
    end
    rd.val <= val_mem[cmd.raddr];
    rd.nxt <= nxt_mem[cmd.raddr];
    rd.prv <= prv_mem[cmd.raddr];
  end

endmodule

// ===== design/ordered_list_store_with_delete_top.sv =====
// top level: circular doubly linked list store with request sequencer
//
// A bounded ring of signed values held in a slot store of CAPACITY entries
// (value, next and previous link memories, one read address and one write
// per memory each cycle). Requests are taken one at a time; req_stall stays
// high until the request's result has been placed in the output register,
// which holds it for the consumer while the next request is taken. An insert
// reads the tail, scans for the lowest free slot one slot per cycle, then
// writes the new entry's links and, if the list was not empty, those of the
// head and tail; an insert into a full store goes straight to its result.
// A search or delete walks the ring from the head one entry per cycle,
// visiting entries up to the match (or the whole list when the value is
// absent); on an empty list it goes straight to its result. The result may
// then wait on rsp_stall.
module ordered_list_store_with_delete_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   operation,
  input  logic signed [31:0]           value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         found,
  output logic [1:0]                   status,
  output logic [olsd_pkg::CNT_W-1:0]   entry_count
);

  olsd_pkg::state_t     state;
  olsd_pkg::state_t     state_next;
  olsd_pkg::op_t        op_reg;
  olsd_pkg::val_t       v_reg;
  olsd_pkg::slot_t      idx;
  olsd_pkg::slot_t      slot;
  olsd_pkg::slot_t      tail;
  olsd_pkg::slot_t      cur;
  olsd_pkg::cnt_t       n;
  olsd_pkg::slot_t      head;
  olsd_pkg::cnt_t       len;
  logic [olsd_pkg::CAPACITY-1:0] in_use;
  logic                 res_found;
  olsd_pkg::status_t    res_status;

  olsd_pkg::store_cmd_t cmd;
  olsd_pkg::store_rd_t  rd;

  logic                 req_xfer;
  logic                 rsp_load;
  logic                 is_insert;
  logic                 full;
  logic                 hit;
  logic                 last;
  olsd_pkg::op_t        req_op;

  olsd_store u_store (
    .clk (clk),
    .cmd (cmd),
    .rd  (rd)
  );

  // request decode and walk conditions
  assign req_op    = olsd_pkg::op_t'(operation);
  assign req_xfer  = req_valid && !req_stall;
  assign is_insert = (req_op == olsd_pkg::OP_INS_FRONT) || (req_op == olsd_pkg::OP_INS_BACK);
  assign full      = (len == olsd_pkg::cnt_t'(olsd_pkg::CAPACITY));
  assign hit       = (rd.val == v_reg);
  assign last      = ((n + olsd_pkg::cnt_t'(1)) == len);
  assign rsp_load  = (state == olsd_pkg::S_DONE) && (!rsp_valid || !rsp_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      olsd_pkg::S_IDLE: begin
        if (req_valid) begin
          if (is_insert) begin
            state_next = full ? olsd_pkg::S_DONE : olsd_pkg::S_TAIL;
          end else begin
            state_next = (len == '0) ? olsd_pkg::S_DONE : olsd_pkg::S_WALK;
          end
        end
      end
      olsd_pkg::S_TAIL: state_next = olsd_pkg::S_SCAN;
      olsd_pkg::S_SCAN: begin
        if (!in_use[idx]) begin
          state_next = olsd_pkg::S_LINK1;
        end
      end
      olsd_pkg::S_LINK1: begin
        state_next = (len == '0) ? olsd_pkg::S_DONE : olsd_pkg::S_LINK2;
      end
      olsd_pkg::S_LINK2: state_next = olsd_pkg::S_DONE;
      olsd_pkg::S_WALK: begin
        if (hit || last) begin
          state_next = olsd_pkg::S_DONE;
        end
      end
      olsd_pkg::S_DONE: begin
        if (rsp_load) begin
          state_next = olsd_pkg::S_IDLE;
        end
      end
      default: state_next = olsd_pkg::S_IDLE;
    endcase
  end

  // store commands and handshake outputs
  always_comb begin
    req_stall     = (state != olsd_pkg::S_IDLE);
    cmd           = '0;
    cmd.raddr     = (state == olsd_pkg::S_WALK) ? rd.nxt : head;
    cmd.val_waddr = slot;
    cmd.val_wdata = v_reg;
    case (state)
      olsd_pkg::S_LINK1: begin
        cmd.val_we    = 1'b1;
        cmd.nxt_we    = 1'b1;
        cmd.prv_we    = 1'b1;
        cmd.nxt_waddr = slot;
        cmd.prv_waddr = slot;
        if (len == '0) begin
          cmd.nxt_wdata = slot;
          cmd.prv_wdata = slot;
        end else begin
          cmd.nxt_wdata = head;
          cmd.prv_wdata = tail;
        end
      end
      olsd_pkg::S_LINK2: begin
        cmd.nxt_we    = 1'b1;
        cmd.nxt_waddr = tail;
        cmd.nxt_wdata = slot;
        cmd.prv_we    = 1'b1;
        cmd.prv_waddr = head;
        cmd.prv_wdata = slot;
      end
      olsd_pkg::S_WALK: begin
        // unlink the matching entry from its neighbors
        if (hit && op_reg == olsd_pkg::OP_DELETE && len > olsd_pkg::cnt_t'(1)) begin
          cmd.nxt_we    = 1'b1;
          cmd.nxt_waddr = rd.prv;
          cmd.nxt_wdata = rd.nxt;
          cmd.prv_we    = 1'b1;
          cmd.prv_waddr = rd.nxt;
          cmd.prv_wdata = rd.prv;
        end
      end
      default: begin
      end
    endcase
  end

  // control state: sequencer, list head, length, slot occupancy, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olsd_pkg::S_IDLE;
      head      <= '0;
      len       <= '0;
      in_use    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        olsd_pkg::S_LINK1: begin
          if (len == '0) begin
            head         <= slot;
            len          <= olsd_pkg::cnt_t'(1);
            in_use[slot] <= 1'b1;
          end
        end
        olsd_pkg::S_LINK2: begin
          len          <= len + olsd_pkg::cnt_t'(1);
          in_use[slot] <= 1'b1;
          if (op_reg == olsd_pkg::OP_INS_FRONT) begin
            head <= slot;
          end
        end
        olsd_pkg::S_WALK: begin
          if (hit && op_reg == olsd_pkg::OP_DELETE) begin
            in_use[cur] <= 1'b0;
            if (len <= olsd_pkg::cnt_t'(1)) begin
              len  <= '0;
              head <= '0;
            end else begin
              len <= len - olsd_pkg::cnt_t'(1);
              if (cur == head) begin
                head <= rd.nxt;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      olsd_pkg::S_IDLE: begin
        if (req_xfer) begin
          op_reg     <= req_op;
          v_reg      <= olsd_pkg::val_t'(value);
          cur        <= head;
          n          <= '0;
          res_found  <= 1'b0;
          if (is_insert && full) begin
            res_status <= olsd_pkg::ST_FULL;
          end else if (!is_insert && len == '0) begin
            res_status <= olsd_pkg::ST_ABSENT;
          end else begin
            res_status <= olsd_pkg::ST_OK;
          end
        end
      end
      olsd_pkg::S_TAIL: begin
        // previous link of the head is the tail
        tail <= rd.prv;
        idx  <= '0;
      end
      olsd_pkg::S_SCAN: begin
        if (in_use[idx]) begin
          idx <= olsd_pkg::slot_t'(idx + 1'b1);
        end else begin
          slot <= idx;
        end
      end
      olsd_pkg::S_WALK: begin
        if (hit) begin
          res_found <= 1'b1;
        end else if (last) begin
          res_status <= olsd_pkg::ST_ABSENT;
        end else begin
          cur <= rd.nxt;
          n   <= n + olsd_pkg::cnt_t'(1);
        end
      end
      default: begin
      end
    endcase
    if (rsp_load) begin
      found       <= res_found;
      status      <= res_status;
      entry_count <= len;
    end
  end

endmodule
